@@ rtl/sld_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_pkg
// Shared types, widths and the luma function of the subsampled luma
// frame difference block.
// ----------------------------------------------------------------------------
package sld_pkg;

  localparam int PIXEL_W     = 16;
  localparam int LUMA_W      = 8;
  localparam int SIDE_CFG_W  = 12;
  localparam int SIDE_CMP_W  = 13;
  localparam int CFG_INDEX_W = 2;
  localparam int COUNT_W     = 19;
  localparam int MEAN_W      = 18;
  localparam int TOTAL_W     = 26;
  localparam int SCALE_W     = 10;
  localparam int PROD_W      = TOTAL_W + SCALE_W;
  localparam int DIV_STEPS   = PROD_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int IN_TDATA_W  = 2 * PIXEL_W;
  localparam int OUT_TDATA_W = ((COUNT_W + MEAN_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - COUNT_W - MEAN_W;

  localparam logic [SIDE_CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [SIDE_CFG_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [SCALE_W-1:0]    MEAN_SCALE   = 10'd1000;

  localparam logic [15:0] LUMA_R = 16'd77;
  localparam logic [15:0] LUMA_G = 16'd150;
  localparam logic [15:0] LUMA_B = 16'd29;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // controller to datapath
  typedef struct packed {
    logic take;      // pixel pair beat accepted
    logic snap;      // scale the total, latch the count, clear accumulators
    logic div_step;  // one restoring division step
    logic load;      // move quotient and count into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic frame_end;
    logic div_last;
    logic out_free;
  } status_t;

  function automatic logic [LUMA_W-1:0] luma_of(input logic [PIXEL_W-1:0] px);
    logic [7:0]  r8;
    logic [7:0]  g8;
    logic [7:0]  b8;
    logic [15:0] sum;
    r8  = {px[15:11], px[15:13]};
    g8  = {px[10:5], px[10:9]};
    b8  = {px[4:0], px[4:2]};
    sum = LUMA_R * {8'd0, r8} + LUMA_G * {8'd0, g8} + LUMA_B * {8'd0, b8};
    return sum[15:8];
  endfunction

endpackage
`default_nettype wire

@@ rtl/sld_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_ctrl
// Sequencer: pixel intake, pipeline drain, scaling, serial divide and
// result hand-off.
// ----------------------------------------------------------------------------
module sld_ctrl (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_tvalid,
  output logic            in_tready,
  input  sld_pkg::status_t status,
  output sld_pkg::cmd_t    cmd
);
  import sld_pkg::*;

  typedef enum logic [4:0] {
    ST_RUN   = 5'b00001,
    ST_DRAIN = 5'b00010,
    ST_MUL   = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_LOAD  = 5'b10000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_tready = (state_r == ST_RUN);

  always_comb begin
    cmd.take     = in_tready & in_tvalid;
    cmd.snap     = (state_r == ST_MUL);
    cmd.div_step = (state_r == ST_DIV);
    cmd.load     = (state_r == ST_LOAD) & status.out_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_RUN: begin
        if (in_tvalid && status.frame_end) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_DIV;
      ST_DIV: begin
        if (status.div_last) state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) state_nxt = ST_RUN;
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sld_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_dp
// Datapath: size registers, raster position, luma stage, accumulators,
// bit-serial restoring divider and output register.
// ----------------------------------------------------------------------------
module sld_dp #(
  parameter int SAMPLE_STEP = 4,
  parameter int MAX_SIDE    = 2048
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_valid,
  input  wire  [sld_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire  [sld_pkg::SIDE_CFG_W-1:0]      cfg_data,
  input  wire  [sld_pkg::IN_TDATA_W-1:0]      in_tdata,
  input  wire                                 out_tready,
  input  sld_pkg::cmd_t                       cmd,
  output sld_pkg::status_t                    status,
  output logic                                out_tvalid,
  output logic [sld_pkg::OUT_TDATA_W-1:0]     out_tdata
);
  import sld_pkg::*;

  localparam int CW = $clog2(MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int PW = (SAMPLE_STEP > 1) ? $clog2(SAMPLE_STEP) : 1;
  localparam logic [PW-1:0]         PH_LAST  = PW'(SAMPLE_STEP - 1);
  localparam logic [SIDE_CMP_W-1:0] SIDE_MAX = SIDE_CMP_W'(MAX_SIDE);

  // size registers
  logic [SIDE_CFG_W-1:0] frame_width_r;
  logic [SIDE_CFG_W-1:0] frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= WIDTH_RESET;
      frame_height_r <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_FRAME_WIDTH)  frame_width_r  <= cfg_data;
      if (cfg_index == REG_FRAME_HEIGHT) frame_height_r <= cfg_data;
    end
  end

  logic [SW-1:0] side_w;
  logic [SW-1:0] side_h;

  // zero acts as one, oversize acts as the maximum side
  always_comb begin
    priority if (frame_width_r == '0) side_w = SW'(1);
    else if ({1'b0, frame_width_r} > SIDE_MAX) side_w = SW'(MAX_SIDE);
    else side_w = SW'(frame_width_r);
    priority if (frame_height_r == '0) side_h = SW'(1);
    else if ({1'b0, frame_height_r} > SIDE_MAX) side_h = SW'(MAX_SIDE);
    else side_h = SW'(frame_height_r);
  end

  // raster position with sample phase counters
  logic [CW-1:0] col_r, col_nxt;
  logic [CW-1:0] row_r, row_nxt;
  logic [PW-1:0] col_ph_r, col_ph_nxt;
  logic [PW-1:0] row_ph_r, row_ph_nxt;
  logic          row_end;
  logic          frame_end;
  logic          sample_hit;

  assign row_end    = (SW'(col_r) + SW'(1)) >= side_w;
  assign frame_end  = row_end && ((SW'(row_r) + SW'(1)) >= side_h);
  assign sample_hit = (col_ph_r == '0) && (row_ph_r == '0);

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    col_ph_nxt = col_ph_r;
    row_ph_nxt = row_ph_r;
    if (cmd.take) begin
      if (!row_end) begin
        col_nxt    = col_r + CW'(1);
        col_ph_nxt = (col_ph_r == PH_LAST) ? '0 : col_ph_r + PW'(1);
      end else begin
        col_nxt    = '0;
        col_ph_nxt = '0;
        if (frame_end) begin
          row_nxt    = '0;
          row_ph_nxt = '0;
        end else begin
          row_nxt    = row_r + CW'(1);
          row_ph_nxt = (row_ph_r == PH_LAST) ? '0 : row_ph_r + PW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      col_ph_r <= '0;
      row_ph_r <= '0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      col_ph_r <= col_ph_nxt;
      row_ph_r <= row_ph_nxt;
    end
  end

  // luma stage
  logic              s1_vld_r;
  logic [LUMA_W-1:0] luma_prev_r;
  logic [LUMA_W-1:0] luma_cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.take & sample_hit;
    end
  end

  always_ff @(posedge clk) begin
    luma_prev_r <= luma_of(in_tdata[PIXEL_W-1:0]);
    luma_cur_r  <= luma_of(in_tdata[2*PIXEL_W-1:PIXEL_W]);
  end

  // accumulators
  logic [TOTAL_W-1:0] total_r;
  logic [COUNT_W-1:0] samples_r;
  logic [LUMA_W-1:0]  abs_diff;

  assign abs_diff = (luma_cur_r >= luma_prev_r) ? (luma_cur_r - luma_prev_r)
                                                : (luma_prev_r - luma_cur_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      samples_r <= '0;
    end else if (cmd.snap) begin
      total_r   <= '0;
      samples_r <= '0;
    end else if (s1_vld_r) begin
      total_r   <= total_r + TOTAL_W'(abs_diff);
      samples_r <= samples_r + COUNT_W'(1);
    end
  end

  // scale and restoring divide, quotient shifts in where the dividend leaves
  logic [COUNT_W-1:0]   n_r;
  logic [PROD_W-1:0]    quo_r;
  logic [COUNT_W:0]     rem_r;
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [COUNT_W:0]     rem_sh;
  logic                 rem_ge;

  assign rem_sh = {rem_r[COUNT_W-1:0], quo_r[PROD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, n_r};

  always_ff @(posedge clk) begin
    if (cmd.snap) begin
      n_r       <= samples_r;
      quo_r     <= {{SCALE_W{1'b0}}, total_r} * {{TOTAL_W{1'b0}}, MEAN_SCALE};
      rem_r     <= '0;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[PROD_W-2:0], rem_ge};
      rem_r     <= rem_ge ? (rem_sh - {1'b0, n_r}) : rem_sh;
      div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
    end
  end

  // output register
  logic                   out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [MEAN_W-1:0]      mean;

  // a count of zero gives a mean of zero
  assign mean = (n_r == '0) ? '0 : quo_r[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) out_data_r <= {{OUT_PAD_W{1'b0}}, mean, n_r};
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    status.frame_end = frame_end;
    status.div_last  = (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
    status.out_free  = !out_vld_r || out_tready;
  end

endmodule
`default_nettype wire

@@ rtl/subsampled_luma_frame_difference.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// subsampled_luma_frame_difference
// Mean absolute luma difference of two RGB565 frames on a sampled grid.
// ----------------------------------------------------------------------------
// in_*  : one beat per co-located pixel pair, raster order; tdata holds
//         previous_pixel in bits 15:0 and current_pixel in bits 31:16.
// out_* : one beat per frame: frame_samples in bits 18:0 and
//         mean_diff_x1000 in bits 36:19, bits 39:37 zero.
// cfg_* : register writes, index 0 frame_width, index 1 frame_height;
//         always ready, other indexes are dropped. Write only when idle.
// Throughput: one pixel beat per cycle inside a frame. After the last
//   pixel of a frame intake pauses through the drain, scale, bit-serial
//   divide and load states; the result appears once the load state has
//   moved it into the output register.
// Stall: the result sits in an output register while pixels of the next
//   frame flow; only if that frame ends before the result is taken does
//   intake wait in the load cycle.
// Reset: sizes return to 640 x 480, position and totals clear, no result.
// ----------------------------------------------------------------------------
module subsampled_luma_frame_difference #(
  parameter int SAMPLE_STEP = 4,
  parameter int MAX_SIDE    = 2048
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_valid,
  output logic                              cfg_ready,
  input  wire  [sld_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire  [sld_pkg::SIDE_CFG_W-1:0]    cfg_data,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  // previous_pixel [15:0], current_pixel [31:16]
  input  wire  [sld_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                              out_tvalid,
  input  wire                               out_tready,
  // frame_samples [18:0], mean_diff_x1000 [36:19], zero pad [39:37]
  output logic [sld_pkg::OUT_TDATA_W-1:0]   out_tdata
);
  import sld_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  sld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  sld_dp #(
    .SAMPLE_STEP (SAMPLE_STEP),
    .MAX_SIDE    (MAX_SIDE)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .cmd        (cmd),
    .status     (status),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

@@ rtl/sld_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sld_checker
// Port-level checks of the subsampled luma frame difference block.
// ----------------------------------------------------------------------------
module sld_checker (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [sld_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import sld_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result beat changed while stalled");

  // a result never follows a pixel beat in the next cycle
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tvalid && in_tready))
    else $error("result appeared right after a pixel beat");

  // intake is open right after reset
  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_tready)
    else $error("input not ready after reset");

endmodule

bind subsampled_luma_frame_difference sld_checker u_sld_checker (.*);
`default_nettype wire

@@ test/tb_subsampled_luma_frame_difference.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_subsampled_luma_frame_difference
// Streams RGB565 pixel pairs into the frame difference block and checks each
// per-frame result against a luma predictor held in the bench. It covers the
// size registers, degenerate and oversized sides, size changes inside a frame,
// and random frames, with bursty input and a stalling result receiver.
// ----------------------------------------------------------------------------
module tb_subsampled_luma_frame_difference;
  import sld_pkg::*;

  localparam int GRID_STEP     = 4;
  localparam int SIDE_LIMIT    = 2048;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int RANDOM_PAIRS  = 1630;

  // indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MEAN_W-1:0]  mean;
  } frame_stats_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_RUNS} rx_mode_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_valid  = 1'b0;
  wire                    cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [SIDE_CFG_W-1:0]  cfg_data   = '0;
  logic                   in_tvalid  = 1'b0;
  wire                    in_tready;
  // previous_pixel [15:0], current_pixel [31:16]
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  wire                    out_tvalid;
  logic                   out_tready = 1'b0;
  // frame_samples [18:0], mean_diff_x1000 [36:19], zero pad [39:37]
  wire [OUT_TDATA_W-1:0]  out_tdata;

  // predictor state
  logic [SIDE_CFG_W-1:0] width_reg;
  logic [SIDE_CFG_W-1:0] height_reg;
  int unsigned           col_pos;
  int unsigned           row_pos;
  logic [TOTAL_W-1:0]    luma_diff_sum;
  logic [COUNT_W-1:0]    grid_samples;
  frame_stats_t          pending_stats[$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;
  int unsigned burst_left     = 0;
  bit          sender_steady  = 1'b0;
  rx_mode_t    rx_mode        = RX_OPEN;
  int unsigned rx_phase_left  = 0;
  int unsigned rx_run_left    = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  subsampled_luma_frame_difference #(
    .SAMPLE_STEP (GRID_STEP),
    .MAX_SIDE    (SIDE_LIMIT)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // ---------------------------------------------------------------- predictor

  // 5/6-bit channels widened to 8 bits by repeating their top bits
  function automatic int unsigned pixel_luma(input logic [PIXEL_W-1:0] px);
    int unsigned red;
    int unsigned grn;
    int unsigned blu;
    red = px[15:11];
    grn = px[10:5];
    blu = px[4:0];
    red = (red << 3) | (red >> 2);
    grn = (grn << 2) | (grn >> 4);
    blu = (blu << 3) | (blu >> 2);
    return (77 * red + 150 * grn + 29 * blu) >> 8;
  endfunction

  function automatic int unsigned clamp_side(input logic [SIDE_CFG_W-1:0] side);
    if (side == 0) begin
      return 1;
    end
    if (side > SIDE_LIMIT) begin
      return SIDE_LIMIT;
    end
    return side;
  endfunction

  task automatic predict_pair(input logic [PIXEL_W-1:0] prev_px,
                              input logic [PIXEL_W-1:0] cur_px);
    int unsigned       w;
    int unsigned       h;
    int unsigned       luma_prev;
    int unsigned       luma_cur;
    longint unsigned   scaled;
    frame_stats_t      stats;
    w = clamp_side(width_reg);
    h = clamp_side(height_reg);
    if ((col_pos % GRID_STEP) == 0 && (row_pos % GRID_STEP) == 0) begin
      luma_prev = pixel_luma(prev_px);
      luma_cur  = pixel_luma(cur_px);
      luma_diff_sum = luma_diff_sum + TOTAL_W'((luma_cur >= luma_prev) ?
                      luma_cur - luma_prev : luma_prev - luma_cur);
      grid_samples = grid_samples + 1'b1;
    end
    // ">=" matters when the width shrank under a column already passed
    if (col_pos + 1 < w) begin
      col_pos++;
    end else begin
      col_pos = 0;
      if (row_pos + 1 < h) begin
        row_pos++;
      end else begin
        scaled = 64'(luma_diff_sum) * 64'd1000;
        scaled = scaled / grid_samples;
        stats.count = grid_samples;
        stats.mean  = scaled[MEAN_W-1:0];
        pending_stats.push_back(stats);
        row_pos       = 0;
        luma_diff_sum = '0;
        grid_samples  = '0;
      end
    end
  endtask

  // ------------------------------------------------------------------ drivers

  task automatic send_pair(input logic [PIXEL_W-1:0] prev_px,
                           input logic [PIXEL_W-1:0] cur_px);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = sender_steady ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tdata  = {cur_px, prev_px};
    do @(posedge clk); while (!in_tready);
    predict_pair(prev_px, cur_px);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [SIDE_CFG_W-1:0]  val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = val;
    end else if (idx == REG_FRAME_HEIGHT) begin
      height_reg = val;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_frame_size(input logic [SIDE_CFG_W-1:0] w,
                                input logic [SIDE_CFG_W-1:0] h);
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
  endtask

  // hold intake until every frame result is out and the divider is quiet
  task automatic wait_frames_drained();
    while (pending_stats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic send_random_pair();
    logic [PIXEL_W-1:0] prev_px;
    logic [PIXEL_W-1:0] cur_px;
    prev_px = PIXEL_W'($urandom);
    case ($urandom_range(0, 5))
      0, 1: cur_px = PIXEL_W'($urandom);
      2: cur_px = prev_px ^ (16'h0001 << $urandom_range(0, 15));
      3: cur_px = prev_px;
      4: begin
        prev_px = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        cur_px  = ~prev_px;
      end
      default: cur_px = ~prev_px;
    endcase
    send_pair(prev_px, cur_px);
  endtask

  function automatic logic [SIDE_CFG_W-1:0] random_side();
    if ($urandom_range(0, 19) == 0) begin
      return '0;
    end
    if ($urandom_range(0, 9) == 0) begin
      return SIDE_CFG_W'($urandom_range(13, 32));
    end
    return SIDE_CFG_W'($urandom_range(1, 12));
  endfunction

  // ---------------------------------------------------------------- receivers

  always @(negedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode       = rx_mode_t'($urandom_range(0, 2));
      rx_phase_left = $urandom_range(50, 300);
    end
    rx_phase_left--;
    case (rx_mode)
      RX_OPEN: out_tready = 1'b1;
      RX_COIN: out_tready = 1'($urandom_range(0, 1));
      default: begin
        if (rx_run_left == 0) begin
          out_tready  = ~out_tready;
          rx_run_left = $urandom_range(1, 50);
        end
        rx_run_left--;
      end
    endcase
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    frame_stats_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("result beat with no frame pending", out_tdata, 0);
      end else begin
        want = pending_stats.pop_front();
        if (out_tdata[COUNT_W-1:0] !== want.count) begin
          report_mismatch("frame_samples", out_tdata[COUNT_W-1:0], want.count);
        end
        if (out_tdata[COUNT_W +: MEAN_W] !== want.mean) begin
          report_mismatch("mean_diff_x1000", out_tdata[COUNT_W +: MEAN_W], want.mean);
        end
        if (out_tdata[OUT_TDATA_W-1 -: OUT_PAD_W] !== '0) begin
          report_mismatch("tdata pad", out_tdata[OUT_TDATA_W-1 -: OUT_PAD_W], 0);
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[%0t] timeout", $time);
    $display("Verification failed");
    $finish;
  end

  // -------------------------------------------------------------------- tests

  // a few pixels at the reset size, then both sides cut to zero mid-row
  task automatic test_reset_size_then_zero_sides();
    send_pair(16'h0000, 16'hFFFF);
    repeat (4) send_random_pair();
    wait_frames_drained();
    set_frame_size('0, '0);
    send_random_pair();
  endtask

  task automatic test_single_pixel_frames();
    wait_frames_drained();
    set_frame_size(12'd1, 12'd1);
    send_pair(16'h0000, 16'hFFFF);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'hFFFF, 16'hFFFF);
    send_pair(16'hF800, 16'h07E0);
    send_pair(16'h001F, 16'h0000);
    send_pair(16'hA5A5, 16'h5A5A);
  endtask

  task automatic test_spare_register_index();
    wait_frames_drained();
    set_frame_size(12'd2, 12'd2);
    write_reg(REG_SPARE_LO, SIDE_CFG_W'($urandom));
    write_reg(REG_SPARE_HI, 12'hFFF);
    repeat (4) send_random_pair();
  endtask

  // every sampled position black against white
  task automatic test_peak_mean();
    wait_frames_drained();
    set_frame_size(12'd5, 12'd1);
    repeat (5) send_pair(16'h0000, 16'hFFFF);
  endtask

  task automatic test_size_change_mid_frame();
    wait_frames_drained();
    set_frame_size(12'd4, 12'd8);
    repeat (11) send_random_pair();
    // width now below the current column: the row closes on the next beat
    wait_frames_drained();
    write_reg(REG_FRAME_WIDTH, 12'd2);
    repeat (3) send_random_pair();
    // height now below the current row: the frame closes at this row end
    wait_frames_drained();
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    repeat (2) send_random_pair();
  endtask

  // oversized sides keep the row and the frame open, a small size closes them
  task automatic test_oversize_sides();
    wait_frames_drained();
    set_frame_size(12'd2049, 12'd1);
    repeat (40) send_random_pair();
    wait_frames_drained();
    write_reg(REG_FRAME_WIDTH, 12'd8);
    send_random_pair();
    wait_frames_drained();
    set_frame_size(12'd1, 12'hFFF);
    repeat (40) send_random_pair();
    wait_frames_drained();
    write_reg(REG_FRAME_HEIGHT, 12'd1);
    send_random_pair();
  endtask

  task automatic test_random_frames();
    int unsigned sent;
    sent = 0;
    while (sent < RANDOM_PAIRS) begin
      if (col_pos == 0 && row_pos == 0) begin
        sender_steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 2) == 0) begin
          wait_frames_drained();
          if ($urandom_range(0, 7) == 0) begin
            write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                      SIDE_CFG_W'($urandom));
          end
          set_frame_size(random_side(), random_side());
        end
      end else if ($urandom_range(0, 249) == 0) begin
        wait_frames_drained();
        set_frame_size(random_side(), random_side());
      end
      send_random_pair();
      sent++;
    end
  endtask

  initial begin
    width_reg     = WIDTH_RESET;
    height_reg    = HEIGHT_RESET;
    col_pos       = 0;
    row_pos       = 0;
    luma_diff_sum = '0;
    grid_samples  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_size_then_zero_sides();
    test_single_pixel_frames();
    test_spare_register_index();
    test_peak_mean();
    test_size_change_mid_frame();
    test_oversize_sides();
    test_random_frames();

    wait_frames_drained();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ subsampled_luma_frame_difference.f @@
rtl/sld_pkg.sv
rtl/sld_ctrl.sv
rtl/sld_dp.sv
rtl/subsampled_luma_frame_difference.sv
rtl/sld_checker.sv
test/tb_subsampled_luma_frame_difference.sv
